/* rtl/sfp_pkg.sv */
// Shared types and constants of the sync framed sensor packet parser.
package sfp_pkg;

  localparam logic [7:0]  SyncFirst    = 8'hAA;
  localparam logic [7:0]  SyncSecond   = 8'h55;
  localparam int unsigned DataBytes    = 11;
  localparam int unsigned NumValues    = 5;
  localparam int unsigned PosW         = $clog2(DataBytes + 1);
  localparam logic [15:0] TimeoutReset = 16'd500;

  localparam logic ActByte = 1'b0;
  localparam logic ActTick = 1'b1;

  typedef struct packed {
    logic       action;
    logic [7:0] rx_byte;
  } in_item_t;

  typedef struct packed {
    logic [15:0] knob_one;
    logic [15:0] knob_two;
    logic [15:0] light_level;
    logic [15:0] joystick_x;
    logic [15:0] joystick_y;
    logic        switch_on;
    logic        frame_good;
    logic        frame_bad;
    logic        link_up;
  } out_item_t;

  typedef struct packed {
    logic [15:0] link_timeout_ms;
  } cfg_item_t;

  typedef struct packed {
    logic [NumValues-1:0][15:0] values;
    logic                       switch_on;
    logic                       good;
    logic                       bad;
  } frame_res_t;

endpackage

/* rtl/sfp_stream_if.sv */
// Valid/ready channel interface carrying one payload beat.
interface sfp_stream_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
  modport mon    (input valid, input data, input ready);
endinterface

/* rtl/sfp_framer.sv */
// Sync hunt, frame collection, XOR check and published value registers.
module sfp_framer (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              byte_en_i,
  input  logic [7:0]        rx_byte_i,
  output sfp_pkg::frame_res_t res_o
);
  import sfp_pkg::*;

  typedef enum logic [2:0] {
    HUNT_FIRST  = 3'b001,
    HUNT_SECOND = 3'b010,
    HUNT_DATA   = 3'b100
  } hunt_e;

  hunt_e                      hunt_q, hunt_d;
  logic [PosW-1:0]            pos_q, pos_d;
  logic [7:0]                 xor_q, xor_d;
  logic [7:0]                 store_q [DataBytes];
  logic                       store_we;
  logic [NumValues-1:0][15:0] pub_q, pub_d;
  logic                       sw_q, sw_d;
  logic                       good, bad;

  always_comb begin
    hunt_d   = hunt_q;
    pos_d    = pos_q;
    xor_d    = xor_q;
    store_we = 1'b0;
    pub_d    = pub_q;
    sw_d     = sw_q;
    good     = 1'b0;
    bad      = 1'b0;
    if (byte_en_i) begin
      case (hunt_q)
        HUNT_SECOND: begin
          if (rx_byte_i == SyncSecond) begin
            hunt_d = HUNT_DATA;
            pos_d  = '0;
            xor_d  = '0;
          end else if (rx_byte_i != SyncFirst) begin
            hunt_d = HUNT_FIRST;
          end
        end
        HUNT_DATA: begin
          if (pos_q < PosW'(DataBytes)) begin
            store_we = 1'b1;
            xor_d    = xor_q ^ rx_byte_i;
            pos_d    = pos_q + PosW'(1);
          end else begin
            if (xor_q == rx_byte_i) begin
              for (int k = 0; k < NumValues; k++) begin
                pub_d[k] = {store_q[2*k+1], store_q[2*k]};
              end
              sw_d = (store_q[DataBytes-1] != 8'h00);
              good = 1'b1;
            end else begin
              bad = 1'b1;
            end
            hunt_d = HUNT_FIRST;
            pos_d  = '0;
          end
        end
        default: begin
          hunt_d = (rx_byte_i == SyncFirst) ? HUNT_SECOND : HUNT_FIRST;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hunt_q <= HUNT_FIRST;
      pos_q  <= '0;
      xor_q  <= '0;
      pub_q  <= '0;
      sw_q   <= 1'b0;
    end else begin
      hunt_q <= hunt_d;
      pos_q  <= pos_d;
      xor_q  <= xor_d;
      pub_q  <= pub_d;
      sw_q   <= sw_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (store_we) begin
      store_q[pos_q] <= rx_byte_i;
    end
  end

  assign res_o.values    = pub_d;
  assign res_o.switch_on = sw_d;
  assign res_o.good      = good;
  assign res_o.bad       = bad;

endmodule

/* rtl/sfp_link_mon.sv */
// Link age counter, timeout register and link status compare.
module sfp_link_mon #(
  parameter int unsigned AGE_BITS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_timeout_i,
  input  logic        tick_i,
  input  logic        good_i,
  output logic        link_up_o
);
  import sfp_pkg::*;

  localparam int unsigned CmpW = (AGE_BITS > 16) ? AGE_BITS : 16;

  logic [AGE_BITS-1:0] age_q, age_d;
  logic [15:0]         timeout_q;

  always_comb begin
    age_d = age_q;
    if (tick_i) begin
      if (age_q != {AGE_BITS{1'b1}}) begin
        age_d = age_q + AGE_BITS'(1);
      end
    end else if (good_i) begin
      age_d = '0;
    end
  end

  assign link_up_o = CmpW'(age_d) < CmpW'(timeout_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      age_q     <= '0;
      timeout_q <= TimeoutReset;
    end else begin
      age_q <= age_d;
      if (cfg_we_i) begin
        timeout_q <= cfg_timeout_i;
      end
    end
  end

endmodule

/* rtl/sync_framed_sensor_packet_parser_core.sv */
// Top level: input register, framer and link monitor, and the result register.
// An accepted input beat passes through the input register and then the result register.
// Throughput is one item per cycle; the input and result registers both advance
// whenever the result register is empty or its beat is taken in that cycle.
// Reset clears the hunt state, the published values and the link age, and
// loads a link timeout of 500 ms, so the link reads as up right after reset.
module sync_framed_sensor_packet_parser_core #(
  parameter int unsigned AGE_BITS = 16
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  sfp_stream_if.sink   in_i,
  sfp_stream_if.source out_o,
  sfp_stream_if.sink   cfg_i
);
  import sfp_pkg::*;

  logic       in_valid_q;
  in_item_t   in_item_q;
  logic       out_valid_q;
  out_item_t  out_data_q, out_data_d;
  logic       out_free, fire;
  frame_res_t res;
  logic       link_up;

  assign out_free    = !out_valid_q || out_o.ready;
  assign fire        = in_valid_q && out_free;
  assign in_i.ready  = !in_valid_q || out_free;
  assign cfg_i.ready = 1'b1;

  sfp_framer u_framer (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .byte_en_i (fire && (in_item_q.action == ActByte)),
    .rx_byte_i (in_item_q.rx_byte),
    .res_o     (res)
  );

  sfp_link_mon #(
    .AGE_BITS (AGE_BITS)
  ) u_link_mon (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_i.valid),
    .cfg_timeout_i (cfg_i.data.link_timeout_ms),
    .tick_i        (fire && (in_item_q.action == ActTick)),
    .good_i        (res.good),
    .link_up_o     (link_up)
  );

  always_comb begin
    out_data_d.knob_one    = res.values[0];
    out_data_d.knob_two    = res.values[1];
    out_data_d.light_level = res.values[2];
    out_data_d.joystick_x  = res.values[3];
    out_data_d.joystick_y  = res.values[4];
    out_data_d.switch_on   = res.switch_on;
    out_data_d.frame_good  = res.good;
    out_data_d.frame_bad   = res.bad;
    out_data_d.link_up     = link_up;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_i.ready) begin
        in_valid_q <= in_i.valid;
      end
      if (fire) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.ready && in_i.valid) begin
      in_item_q <= in_i.data;
    end
    if (fire) begin
      out_data_q <= out_data_d;
    end
  end

  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_data_q;

endmodule

/* rtl/sfp_checker.sv */
// Port-level checker for the parser core and its bind statement.
module sfp_checker (
  input logic          clk_i,
  input logic          rst_ni,
  sfp_stream_if.sink   in_i,
  sfp_stream_if.source out_o
);
  import sfp_pkg::*;

  logic       in_beat, out_beat;
  logic [1:0] pending_q;
  logic       seen_q;
  out_item_t  last_q;

  assign in_beat  = in_i.valid && in_i.ready;
  assign out_beat = out_o.valid && out_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pending_q <= '0;
      seen_q    <= 1'b0;
    end else begin
      pending_q <= pending_q + {1'b0, in_beat} - {1'b0, out_beat};
      if (out_beat) begin
        seen_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_beat) begin
      last_q <= out_o.data;
    end
  end

  a_no_result_without_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid |-> (pending_q != 2'd0))
    else $error("Result beat shown without an outstanding input item.");

  a_in_flight_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pending_q == 2'd2) |-> !(in_beat && !out_beat))
    else $error("More than two items in flight.");

  a_good_bad_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid |-> !(out_o.data.frame_good && out_o.data.frame_bad))
    else $error("Frame flagged both good and bad.");

  a_values_change_on_good: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && seen_q && !out_o.data.frame_good) |->
      ((out_o.data.knob_one == last_q.knob_one) &&
       (out_o.data.knob_two == last_q.knob_two) &&
       (out_o.data.light_level == last_q.light_level) &&
       (out_o.data.joystick_x == last_q.joystick_x) &&
       (out_o.data.joystick_y == last_q.joystick_y) &&
       (out_o.data.switch_on == last_q.switch_on)))
    else $error("Published values changed without a good frame.");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && !out_o.ready) |=> (out_o.valid && $stable(out_o.data)))
    else $error("Stalled result beat changed.");

endmodule

bind sync_framed_sensor_packet_parser_core sfp_checker u_sfp_checker (
  .clk_i  (clk_i),
  .rst_ni (rst_ni),
  .in_i   (in_i),
  .out_o  (out_o)
);
